// ----- hdl/packed_bit_field_array_macros.svh -----
// ----------------------------------------------------------------------------
// packed bit-field array assertion macros
// shared concurrent assertion forms used by the rtl
// ----------------------------------------------------------------------------
`ifndef PACKED_BIT_FIELD_ARRAY_MACROS_SVH
`define PACKED_BIT_FIELD_ARRAY_MACROS_SVH

`ifndef NO_ASSERTIONS

`define PBFA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define PBFA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define PBFA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)

`define PBFA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ----- hdl/pbfa_pkg.sv -----
// ----------------------------------------------------------------------------
// pbfa_pkg
// widths, codes, types and layout tables of the packed bit-field array
// ----------------------------------------------------------------------------
package pbfa_pkg;

    localparam int MAX_ENTRIES = 4096;
    localparam int WORD_DEPTH  = 2048;
    localparam int WORD_AW     = $clog2(WORD_DEPTH);

    localparam int FUNC_W      = 1;
    localparam int IDX_W       = 12;
    localparam int VAL_W       = 32;
    localparam int STATUS_W    = 2;
    localparam int WIDTH_W     = 6;
    localparam int COUNT_W     = 13;
    localparam int WORD_W      = 64;
    localparam int SHIFT_W     = $clog2(WORD_W);
    localparam int PW_W        = 7;
    localparam int RECIP_W     = 16;
    localparam int PROD_W      = IDX_W + RECIP_W;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = COUNT_W;

    localparam logic [FUNC_W-1:0] FUNC_READ  = 1'b0;
    localparam logic [FUNC_W-1:0] FUNC_WRITE = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_RANGE  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_MASKED = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_WIDTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT = 1'b1;

    typedef struct packed {
        logic [PW_W-1:0]    per_word;
        logic [RECIP_W-1:0] recip;
    } layout_t;

    typedef struct packed {
        logic               valid;
        logic [IDX_W-1:0]   word;
        logic [SHIFT_W-1:0] shift;
    } loc_t;

    function automatic logic [WIDTH_W-1:0] eff_width(input logic [WIDTH_W-1:0] w);
        logic [WIDTH_W-1:0] r;
        r = w;
        if (w == '0)
            r = WIDTH_W'(1);
        else if (w > WIDTH_W'(32))
            r = WIDTH_W'(32);
        return r;
    endfunction

    // elements per word and floor(2^16 / per_word)
    function automatic layout_t layout(input logic [WIDTH_W-1:0] w);
        layout_t l;
        case (w) inside
            6'd1:         l = '{per_word: 7'd64, recip: 16'd1024};
            6'd2:         l = '{per_word: 7'd32, recip: 16'd2048};
            6'd3:         l = '{per_word: 7'd21, recip: 16'd3120};
            6'd4:         l = '{per_word: 7'd16, recip: 16'd4096};
            6'd5:         l = '{per_word: 7'd12, recip: 16'd5461};
            6'd6:         l = '{per_word: 7'd10, recip: 16'd6553};
            6'd7:         l = '{per_word: 7'd9,  recip: 16'd7281};
            6'd8:         l = '{per_word: 7'd8,  recip: 16'd8192};
            6'd9:         l = '{per_word: 7'd7,  recip: 16'd9362};
            6'd10:        l = '{per_word: 7'd6,  recip: 16'd10922};
            [6'd11:6'd12]: l = '{per_word: 7'd5,  recip: 16'd13107};
            [6'd13:6'd16]: l = '{per_word: 7'd4,  recip: 16'd16384};
            [6'd17:6'd21]: l = '{per_word: 7'd3,  recip: 16'd21845};
            default:      l = '{per_word: 7'd2,  recip: 16'd32768};
        endcase
        return l;
    endfunction

endpackage

// ----- hdl/pbfa_req_if.sv -----
// ----------------------------------------------------------------------------
// pbfa_req_if
// request channel: one element access per word
// ----------------------------------------------------------------------------
interface pbfa_req_if;
    import pbfa_pkg::*;

    logic                valid;
    logic                ready;
    logic [FUNC_W-1:0]   func;
    logic [IDX_W-1:0]    index;
    logic [VAL_W-1:0]    value;

    modport source (output valid, output func, output index, output value, input ready);
    modport sink   (input valid, input func, input index, input value, output ready);
endinterface

// ----- hdl/pbfa_rsp_if.sv -----
// ----------------------------------------------------------------------------
// pbfa_rsp_if
// response channel: read data and status per word
// ----------------------------------------------------------------------------
interface pbfa_rsp_if;
    import pbfa_pkg::*;

    logic                valid;
    logic                ready;
    logic [VAL_W-1:0]    read_value;
    logic [STATUS_W-1:0] status;

    modport source (output valid, output read_value, output status, input ready);
    modport sink   (input valid, input read_value, input status, output ready);
endinterface

// ----- hdl/packed_bit_field_array.sv -----
// ----------------------------------------------------------------------------
// packed_bit_field_array
// store of 1..32 bit elements packed into 64-bit words, none spanning words
// ----------------------------------------------------------------------------
// One access is in flight at a time. The index-to-word pipeline (reciprocal
// multiply and remainder fix-up) yields the word and bit offset; the word is
// then captured from the synchronous memory, and the merge, write-back and
// loading of the result register follow once the output register is free or
// being taken. The block takes no new word until the result is loaded. A
// finished result waits in its output register while the next word is
// accepted. After reset the 2048-word memory is cleared one word per cycle;
// no request is accepted during that clearing pass, while configuration
// writes are taken.
// ----------------------------------------------------------------------------
`include "packed_bit_field_array_macros.svh"

module packed_bit_field_array (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [pbfa_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pbfa_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    pbfa_req_if.sink                          req,
    pbfa_rsp_if.source                        rsp
);
    import pbfa_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_LOCATE = 2'd1;
    localparam logic [1:0] ST_ACCESS = 2'd2;

    logic [1:0]            state_reg, state_next;

    logic [WIDTH_W-1:0]    width_cfg_reg;
    logic [COUNT_W-1:0]    count_cfg_reg;

    logic                  clr_reg;
    logic [WORD_AW-1:0]    clr_addr_reg;

    logic [FUNC_W-1:0]     func_reg;
    logic [VAL_W-1:0]      val_reg;
    logic [WIDTH_W-1:0]    w_reg;
    logic                  cnt_err_reg;
    logic                  err_reg;
    logic [WORD_AW-1:0]    addr_reg;
    logic [SHIFT_W-1:0]    shift_reg;
    logic [WORD_W-1:0]     rdata_reg;

    logic                  out_valid_reg;
    logic [VAL_W-1:0]      read_value_reg;
    logic [STATUS_W-1:0]   status_reg;

    logic [WORD_W-1:0]     mem [WORD_DEPTH];

    logic                  accept;
    logic                  out_load;
    logic [WIDTH_W-1:0]    w_eff;
    logic [31:0]           count_eff;
    logic                  word_err;
    loc_t                  loc;

    logic [WORD_W-1:0]     mask;
    logic [WORD_W-1:0]     field;
    logic [WORD_W-1:0]     val_ext;
    logic [WORD_W-1:0]     merged;
    logic                  wide;
    logic                  mem_we;
    logic [WORD_AW-1:0]    mem_waddr;
    logic [WORD_W-1:0]     mem_wdata;

    assign w_eff     = eff_width(width_cfg_reg);
    assign count_eff = (32'(count_cfg_reg) > 32'(MAX_ENTRIES)) ? 32'(MAX_ENTRIES)
                                                              : 32'(count_cfg_reg);

    assign req.ready = (state_reg == ST_IDLE) && !clr_reg;
    assign accept    = req.valid && req.ready;

    pbfa_locate u_locate (
        .clk   (clk),
        .rst_n (rst_n),
        .start (accept),
        .index (req.index),
        .width (w_eff),
        .loc   (loc)
    );

    assign word_err = 32'(loc.word) >= 32'(WORD_DEPTH);

    // config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_cfg_reg <= WIDTH_W'(1);
            count_cfg_reg <= COUNT_W'(4096);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_WIDTH: width_cfg_reg <= cfg_wdata[WIDTH_W-1:0];
                REG_COUNT: count_cfg_reg <= cfg_wdata[COUNT_W-1:0];
                default:   ;
            endcase
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (accept) state_next = ST_LOCATE;
            ST_LOCATE: if (loc.valid) state_next = ST_ACCESS;
            ST_ACCESS: if (out_load) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            clr_reg      <= 1'b1;
            clr_addr_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (clr_reg)
            begin
                clr_addr_reg <= clr_addr_reg + WORD_AW'(1);
                if (clr_addr_reg == WORD_AW'(WORD_DEPTH - 1))
                    clr_reg <= 1'b0;
            end
        end
    end

    // request capture
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg    <= req.func;
            val_reg     <= req.value;
            w_reg       <= w_eff;
            cnt_err_reg <= 32'(req.index) >= count_eff;
        end
        if (state_reg == ST_LOCATE && loc.valid)
        begin
            err_reg   <= cnt_err_reg || word_err;
            addr_reg  <= WORD_AW'(loc.word);
            shift_reg <= loc.shift;
            rdata_reg <= mem[WORD_AW'(loc.word)];
        end
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
    end

    // field extract and merge
    always_comb
    begin
        mask    = (WORD_W'(1) << w_reg) - WORD_W'(1);
        field   = (rdata_reg >> shift_reg) & mask;
        val_ext = WORD_W'(val_reg) & mask;
        wide    = (WORD_W'(val_reg) & ~mask) != '0;
        merged  = (rdata_reg & ~(mask << shift_reg)) | (val_ext << shift_reg);
    end

    assign out_load  = (state_reg == ST_ACCESS) && (!out_valid_reg || rsp.ready);
    assign mem_we    = clr_reg || (out_load && !err_reg && func_reg == FUNC_WRITE);
    assign mem_waddr = clr_reg ? clr_addr_reg : addr_reg;
    assign mem_wdata = clr_reg ? '0 : merged;

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (rsp.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            if (err_reg)
            begin
                read_value_reg <= '0;
                status_reg     <= STATUS_RANGE;
            end
            else if (func_reg == FUNC_WRITE)
            begin
                read_value_reg <= '0;
                status_reg     <= wide ? STATUS_MASKED : STATUS_OK;
            end
            else
            begin
                read_value_reg <= field[VAL_W-1:0];
                status_reg     <= STATUS_OK;
            end
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.read_value = read_value_reg;
    assign rsp.status     = status_reg;

    `PBFA_ASSERT_NXT(a_accept_to_locate, clk, rst_n, accept, state_reg == ST_LOCATE,
        "accepted word did not enter locate")
    `PBFA_ASSERT_IMP(a_loc_in_locate, clk, rst_n, loc.valid, state_reg == ST_LOCATE,
        "locate result outside locate state")
    `PBFA_ASSERT_IMP(a_no_write_while_clear, clk, rst_n, clr_reg, state_reg == ST_IDLE,
        "access in flight during clearing pass")
    `PBFA_ASSERT_IMP(a_clear_end, clk, rst_n, $fell(clr_reg),
        $past(clr_addr_reg) == WORD_AW'(WORD_DEPTH - 1), "clearing pass ended early")
    `PBFA_ASSERT_NXT(a_masked_only_write, clk, rst_n, out_load && func_reg == FUNC_READ,
        status_reg != STATUS_MASKED, "masked status on read")

endmodule

// ----- hdl/pbfa_locate.sv -----
// ----------------------------------------------------------------------------
// pbfa_locate
// four-stage pipeline mapping an element index to its word and bit offset
// ----------------------------------------------------------------------------
`include "packed_bit_field_array_macros.svh"

module pbfa_locate (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [pbfa_pkg::IDX_W-1:0]      index,
    input  logic [pbfa_pkg::WIDTH_W-1:0]    width,
    output pbfa_pkg::loc_t                  loc
);
    import pbfa_pkg::*;

    layout_t               lay;

    logic                  v1_reg, v2_reg, v3_reg, v4_reg;
    logic [IDX_W-1:0]      idx1_reg, idx2_reg;
    logic [WIDTH_W-1:0]    w1_reg, w2_reg, w3_reg;
    logic [PW_W-1:0]       pw1_reg, pw2_reg;
    logic [RECIP_W-1:0]    r1_reg;
    logic [PROD_W-1:0]     prod2_reg;
    logic [IDX_W-1:0]      q3_reg, q3_next;
    logic [SHIFT_W-1:0]    rem3_reg, rem3_next;
    logic [IDX_W-1:0]      word4_reg;
    logic [SHIFT_W-1:0]    shift4_reg;

    logic [IDX_W-1:0]      q0;
    logic [IDX_W-1:0]      r0;
    logic [IDX_W+PW_W-1:0] qp;
    logic [2*WIDTH_W-1:0]  shift_full;

    assign lay = layout(width);

    always_comb
    begin
        q0 = prod2_reg[PROD_W-1:RECIP_W];
        qp = IDX_W'(q0) * pw2_reg;
        r0 = idx2_reg - qp[IDX_W-1:0];
        // the estimate is low by at most one
        if (r0 >= IDX_W'(pw2_reg))
        begin
            q3_next   = q0 + IDX_W'(1);
            rem3_next = SHIFT_W'(r0 - IDX_W'(pw2_reg));
        end
        else
        begin
            q3_next   = q0;
            rem3_next = SHIFT_W'(r0);
        end
    end

    assign shift_full = rem3_reg * w3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        idx1_reg   <= index;
        w1_reg     <= width;
        pw1_reg    <= lay.per_word;
        r1_reg     <= lay.recip;

        idx2_reg   <= idx1_reg;
        w2_reg     <= w1_reg;
        pw2_reg    <= pw1_reg;
        prod2_reg  <= idx1_reg * r1_reg;

        q3_reg     <= q3_next;
        rem3_reg   <= rem3_next;
        w3_reg     <= w2_reg;

        word4_reg  <= q3_reg;
        shift4_reg <= shift_full[SHIFT_W-1:0];
    end

    assign loc.valid = v4_reg;
    assign loc.word  = word4_reg;
    assign loc.shift = shift4_reg;

    `PBFA_ASSERT_IMP(a_rem_below_per_word, clk, rst_n, v3_reg,
        PW_W'(rem3_reg) < $past(pw2_reg), "remainder too large")
    `PBFA_ASSERT_NXT(a_pipe_advance, clk, rst_n, start, v1_reg, "locate stage lost")
    `PBFA_ASSERT_IMP(a_shift_fits, clk, rst_n, v4_reg,
        32'(shift4_reg) + 32'($past(w3_reg)) <= 32'(WORD_W), "field beyond word")

endmodule
